FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// expects clk and rst in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define IDV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define IDV_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/idv_pkg.sv
// idv_pkg: types, constants and helper functions of the id number validator
// no dependencies
package idv_pkg;

  localparam int CHAR_W      = 8;
  localparam int YEAR_W      = 14;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int BFIELD_W    = 7;
  localparam int DAYS_W      = 22;
  localparam int NUM_W       = 23;
  localparam int POS_W       = 5;
  localparam int SUM_W       = 4;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int QUEUE_DEPTH = 4;

  // result status codes
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_AFTER   = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_YEAR  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MONTH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DAY   = 2'd2;

  localparam logic [YEAR_W-1:0]  REF_YEAR_RST  = 14'd2019;
  localparam logic [MONTH_W-1:0] REF_MONTH_RST = 4'd4;
  localparam logic [DAY_W-1:0]   REF_DAY_RST   = 5'd2;

  localparam logic [DAYS_W-1:0] DAYS_MAX = 22'h3FFFFF;

  // character positions
  localparam logic [POS_W-1:0] POS_YEAR_FIRST  = 5'd6;
  localparam logic [POS_W-1:0] POS_YEAR_LAST   = 5'd9;
  localparam logic [POS_W-1:0] POS_MONTH_FIRST = 5'd10;
  localparam logic [POS_W-1:0] POS_MONTH_LAST  = 5'd11;
  localparam logic [POS_W-1:0] POS_DAY_FIRST   = 5'd12;
  localparam logic [POS_W-1:0] POS_DAY_LAST    = 5'd13;
  localparam logic [POS_W-1:0] POS_CHECK       = 5'd17;
  localparam logic [POS_W-1:0] POS_SAT         = 5'd19;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_X_UP = 8'h58;
  localparam logic [CHAR_W-1:0] CH_X_LO = 8'h78;

  // reciprocal of 100, exact for dividends below 43699
  localparam int RECIP100     = 5243;
  localparam int RECIP_SHIFT  = 19;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } char_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DAYS_W-1:0] days_lived;
  } res_t;

  // one finished id handed from front to back
  typedef struct packed {
    logic                pre_ok;
    logic [YEAR_W-1:0]   year;
    logic [BFIELD_W-1:0] month;
    logic [BFIELD_W-1:0] day;
  } rec_t;

  function automatic logic [3:0] weight(input logic [POS_W-1:0] pos);
    logic [3:0] w;
    case (pos)
      5'd0:    w = 4'd7;
      5'd1:    w = 4'd9;
      5'd2:    w = 4'd10;
      5'd3:    w = 4'd5;
      5'd4:    w = 4'd8;
      5'd5:    w = 4'd4;
      5'd6:    w = 4'd2;
      5'd7:    w = 4'd1;
      5'd8:    w = 4'd6;
      5'd9:    w = 4'd3;
      5'd10:   w = 4'd7;
      5'd11:   w = 4'd9;
      5'd12:   w = 4'd10;
      5'd13:   w = 4'd5;
      5'd14:   w = 4'd8;
      5'd15:   w = 4'd4;
      5'd16:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] month_len(input logic [BFIELD_W-1:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      7'd2:                         n = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:      n = 5'd30;
      default:                      n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic date_ok(input logic [BFIELD_W-1:0] m,
                                   input logic [BFIELD_W-1:0] d, input logic leap);
    return (m != '0) && (m <= 7'd12) && (d != '0) && (d <= 7'(month_len(m, leap)));
  endfunction

  // remainder by 11 for values up to 127
  function automatic logic [SUM_W-1:0] mod11(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(x) * 15'd187;
    q    = prod[14:11];
    r    = x - 7'(7'(q) * 7'd11);
    return r[SUM_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/idv_queue.sv
// idv_queue: small register queue between front and back
// depends on idv_pkg
module idv_queue #(
  parameter int DEPTH = idv_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  idv_pkg::rec_t din,
  output logic          full,
  input  logic          pop,
  output idv_pkg::rec_t dout,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  idv_pkg::rec_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/idv_day_num.sv
// idv_day_num: three-stage day number unit, days since 0000-01-01
// depends on idv_pkg
module idv_day_num (
  input  logic                         clk,
  input  logic                         en,
  input  logic [idv_pkg::YEAR_W-1:0]   y,
  input  logic [idv_pkg::MONTH_W-1:0]  m,
  input  logic [idv_pkg::DAY_W-1:0]    d,
  output logic [idv_pkg::NUM_W-1:0]    num,
  output logic                         leap
);

  localparam int QW = 27;

  logic [idv_pkg::NUM_W-1:0]   s1_p365;
  logic [QW-1:0]               s1_qy;
  logic [QW-1:0]               s1_qa;
  logic [QW-1:0]               s1_qb;
  logic [12:0]                 s1_c4;
  logic [3:0]                  s1_ylo;
  logic [idv_pkg::MONTH_W-1:0] s1_m;
  logic [idv_pkg::DAY_W-1:0]   s1_d;

  logic [7:0] q100;
  logic [7:0] c100;
  logic [7:0] c400;
  logic       leap2;

  logic [idv_pkg::NUM_W-1:0]   s2_n0;
  logic                        s2_leap;
  logic [idv_pkg::MONTH_W-1:0] s2_m;
  logic [idv_pkg::DAY_W-1:0]   s2_d;

  // floor(y/100), ceil(y/100) and ceil(y/400) by reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p365 <= idv_pkg::NUM_W'(y) * 23'd365;
      s1_qy   <= QW'(y) * QW'(idv_pkg::RECIP100);
      s1_qa   <= (QW'(y) + QW'(99)) * QW'(idv_pkg::RECIP100);
      s1_qb   <= QW'((15'(y) + 15'd399) >> 2) * QW'(idv_pkg::RECIP100);
      s1_c4   <= 13'((15'(y) + 15'd3) >> 2);
      s1_ylo  <= y[3:0];
      s1_m    <= m;
      s1_d    <= d;
    end
  end

  assign q100 = s1_qy[QW-1:idv_pkg::RECIP_SHIFT];
  assign c100 = s1_qa[QW-1:idv_pkg::RECIP_SHIFT];
  assign c400 = s1_qb[QW-1:idv_pkg::RECIP_SHIFT];
  // divisible by 100 exactly when floor and ceil agree
  assign leap2 = ((s1_ylo[1:0] == 2'd0) && (q100 != c100)) ||
                 ((q100 == c100) && (s1_ylo == 4'd0));

  always_ff @(posedge clk) begin
    if (en) begin
      s2_n0   <= s1_p365 + idv_pkg::NUM_W'(s1_c4) - idv_pkg::NUM_W'(c100)
                 + idv_pkg::NUM_W'(c400);
      s2_leap <= leap2;
      s2_m    <= s1_m;
      s2_d    <= s1_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num  <= s2_n0 + idv_pkg::NUM_W'(idv_pkg::days_before(s2_m))
              + idv_pkg::NUM_W'((s2_m > 4'd2) && s2_leap)
              + idv_pkg::NUM_W'(s2_d) - 23'd1;
      leap <= s2_leap;
    end
  end

endmodule

FILE: hw/rtl/idv_front.sv
// idv_front: takes one character per beat, keeps check sum and date fields
// depends on idv_pkg
module idv_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           char_valid,
  output logic           char_stall,
  input  idv_pkg::char_t char_beat,
  input  logic           full,
  output logic           push,
  output idv_pkg::rec_t  rec
);

  logic [idv_pkg::POS_W-1:0]    position, position_next;
  logic [idv_pkg::SUM_W-1:0]    wsum, wsum_next;
  logic                         nondigit, nondigit_next;
  logic [idv_pkg::YEAR_W-1:0]   by, by_next;
  logic [idv_pkg::BFIELD_W-1:0] bm, bm_next;
  logic [idv_pkg::BFIELD_W-1:0] bd, bd_next;

  logic                      accept;
  logic                      is_digit;
  logic                      is_x;
  logic [3:0]                dg;
  logic [6:0]                term;
  logic [3:0]                exp_raw;
  logic [3:0]                expect_val;
  logic [3:0]                got;

  assign accept   = char_valid && !full;
  assign char_stall = full;
  assign push     = accept && char_beat.last_char;
  assign is_digit = (char_beat.character >= idv_pkg::CH_ZERO) &&
                    (char_beat.character <= idv_pkg::CH_NINE);
  assign is_x     = (char_beat.character == idv_pkg::CH_X_UP) ||
                    (char_beat.character == idv_pkg::CH_X_LO);
  assign dg       = char_beat.character[3:0];
  assign term     = 7'(dg) * 7'(idv_pkg::weight(position));

  // check value (12 - sum) mod 11 against the current character
  assign exp_raw    = 4'd12 - wsum;
  assign expect_val = (exp_raw >= 4'd11) ? exp_raw - 4'd11 : exp_raw;
  assign got        = is_x ? 4'd10 : dg;

  always_comb begin
    rec.pre_ok = (position == idv_pkg::POS_CHECK) && !nondigit &&
                 (is_digit || is_x) && (got == expect_val);
    rec.year   = by;
    rec.month  = bm;
    rec.day    = bd;
  end

  always_comb begin
    position_next = position;
    wsum_next     = wsum;
    nondigit_next = nondigit;
    by_next       = by;
    bm_next       = bm;
    bd_next       = bd;
    if (accept) begin
      if (char_beat.last_char) begin
        position_next = '0;
        wsum_next     = '0;
        nondigit_next = 1'b0;
        by_next       = '0;
        bm_next       = '0;
        bd_next       = '0;
      end else begin
        if (position < idv_pkg::POS_CHECK) begin
          if (is_digit) begin
            wsum_next = idv_pkg::mod11(7'(wsum) + term);
            if (position >= idv_pkg::POS_YEAR_FIRST && position <= idv_pkg::POS_YEAR_LAST) begin
              by_next = (by << 3) + (by << 1) + idv_pkg::YEAR_W'(dg);
            end else if (position >= idv_pkg::POS_MONTH_FIRST &&
                         position <= idv_pkg::POS_MONTH_LAST) begin
              bm_next = (bm << 3) + (bm << 1) + idv_pkg::BFIELD_W'(dg);
            end else if (position >= idv_pkg::POS_DAY_FIRST &&
                         position <= idv_pkg::POS_DAY_LAST) begin
              bd_next = (bd << 3) + (bd << 1) + idv_pkg::BFIELD_W'(dg);
            end
          end else begin
            nondigit_next = 1'b1;
          end
        end
        if (position < idv_pkg::POS_SAT) begin
          position_next = position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      wsum     <= '0;
      nondigit <= 1'b0;
      by       <= '0;
      bm       <= '0;
      bd       <= '0;
    end else begin
      position <= position_next;
      wsum     <= wsum_next;
      nondigit <= nondigit_next;
      by       <= by_next;
      bm       <= bm_next;
      bd       <= bd_next;
    end
  end

endmodule

FILE: hw/rtl/idv_back.sv
// idv_back: date checks and day count pipeline with output register
// depends on idv_pkg and idv_day_num
module idv_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  output logic                        pop,
  input  idv_pkg::rec_t               rec,
  input  logic [idv_pkg::YEAR_W-1:0]  ref_year,
  input  logic [idv_pkg::MONTH_W-1:0] ref_month,
  input  logic [idv_pkg::DAY_W-1:0]   ref_day,
  output logic                        res_valid,
  input  logic                        res_stall,
  output idv_pkg::res_t               res_beat
);

  typedef struct packed {
    logic                         pre_ok;
    logic [idv_pkg::BFIELD_W-1:0] bm;
    logic [idv_pkg::BFIELD_W-1:0] bd;
    logic [idv_pkg::MONTH_W-1:0]  rm;
    logic [idv_pkg::DAY_W-1:0]    rd;
  } side_t;

  logic  en;
  logic  v1, v2, v3;
  side_t side0, side1, side2, side3;

  logic [idv_pkg::NUM_W-1:0] nb;
  logic [idv_pkg::NUM_W-1:0] nr;
  logic                      leap_b;
  logic                      leap_r;
  logic                      b_ok;
  logic                      r_ok;
  logic [idv_pkg::NUM_W-1:0] diff;
  idv_pkg::res_t             res_next;

  assign en  = !res_valid || !res_stall;
  assign pop = en && !empty;

  always_comb begin
    side0.pre_ok = rec.pre_ok;
    side0.bm     = rec.month;
    side0.bd     = rec.day;
    side0.rm     = ref_month;
    side0.rd     = ref_day;
  end

  idv_day_num u_birth (
    .clk  (clk),
    .en   (en),
    .y    (rec.year),
    .m    (rec.month[idv_pkg::MONTH_W-1:0]),
    .d    (rec.day[idv_pkg::DAY_W-1:0]),
    .num  (nb),
    .leap (leap_b)
  );

  idv_day_num u_ref (
    .clk  (clk),
    .en   (en),
    .y    (ref_year),
    .m    (ref_month),
    .d    (ref_day),
    .num  (nr),
    .leap (leap_r)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side1    <= side0;
      side2    <= side1;
      side3    <= side2;
      res_beat <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= pop;
      v2        <= v1;
      v3        <= v2;
      res_valid <= v3;
    end
  end

  assign b_ok = idv_pkg::date_ok(side3.bm, side3.bd, leap_b);
  assign r_ok = idv_pkg::date_ok(idv_pkg::BFIELD_W'(side3.rm),
                                 idv_pkg::BFIELD_W'(side3.rd), leap_r);
  assign diff = nr - nb;

  always_comb begin
    res_next.status     = idv_pkg::ST_INVALID;
    res_next.days_lived = '0;
    if (side3.pre_ok && b_ok) begin
      if (!r_ok || (nb > nr)) begin
        res_next.status = idv_pkg::ST_AFTER;
      end else begin
        res_next.status     = idv_pkg::ST_VALID;
        res_next.days_lived = diff[idv_pkg::NUM_W-1] ? idv_pkg::DAYS_MAX
                                                     : diff[idv_pkg::DAYS_W-1:0];
      end
    end
  end

endmodule

FILE: hw/rtl/id_number_date_and_check_digit_validator_unit.sv
// id_number_date_and_check_digit_validator_unit: top level of the id validator
// depends on idv_pkg, idv_front, idv_queue, idv_back
//
// usage:
// - char channel: one ascii character of an 18-char id per beat, last_char set
//   on the final character. a beat may come each cycle while char_stall is low.
// - res channel: one result per id, for the beat with last_char: status valid
//   with days_lived, invalid, or after (born later, or bad reference date).
// - cfg port: cfg_we with cfg_addr 0/1/2 writes reference year/month/day;
//   the user writes only while no id is in flight; the block does not check.
// - results pass the queue, the day number pipeline and output register;
//   throughput is one character per cycle while char_stall is low.
// - the day number pipeline has 3 stages; the output register adds one more
//   stage.
// - when res_stall and res_valid are high the result register and pipeline
//   hold; QDEPTH finished ids fit in the queue; char_stall rises when full.
// - reset clears the stream state, the queue and res_valid, and loads the
//   reference date 2019-04-02.
module id_number_date_and_check_digit_validator_unit #(
  parameter int QDEPTH = idv_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           char_valid,
  output logic                           char_stall,
  input  idv_pkg::char_t                 char_beat,
  output logic                           res_valid,
  input  logic                           res_stall,
  output idv_pkg::res_t                  res_beat,
  input  logic                           cfg_we,
  input  logic [idv_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [idv_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [idv_pkg::YEAR_W-1:0]  ref_year;
  logic [idv_pkg::MONTH_W-1:0] ref_month;
  logic [idv_pkg::DAY_W-1:0]   ref_day;

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  idv_pkg::rec_t q_din;
  idv_pkg::rec_t q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_year  <= idv_pkg::REF_YEAR_RST;
      ref_month <= idv_pkg::REF_MONTH_RST;
      ref_day   <= idv_pkg::REF_DAY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        idv_pkg::REG_YEAR:  ref_year  <= cfg_data;
        idv_pkg::REG_MONTH: ref_month <= cfg_data[idv_pkg::MONTH_W-1:0];
        idv_pkg::REG_DAY:   ref_day   <= cfg_data[idv_pkg::DAY_W-1:0];
        default: ;
      endcase
    end
  end

  idv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat),
    .full       (q_full),
    .push       (q_push),
    .rec        (q_din)
  );

  idv_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  idv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .pop       (q_pop),
    .rec       (q_dout),
    .ref_year  (ref_year),
    .ref_month (ref_month),
    .ref_day   (ref_day),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat)
  );

endmodule

FILE: hw/rtl/idv_checker.sv
// idv_checker: assertions on the result port of the id validator
// depends on idv_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module idv_checker (
  input logic          clk,
  input logic          rst,
  input logic          res_valid,
  input logic          res_stall,
  input idv_pkg::res_t res_beat
);

  `IDV_ASSERT(a_res_hold, (res_valid && res_stall) |=> (res_valid && $stable(res_beat)), "result changed while stalled")
  `IDV_ASSERT(a_status_code, res_valid |-> (res_beat.status == idv_pkg::ST_VALID || res_beat.status == idv_pkg::ST_INVALID || res_beat.status == idv_pkg::ST_AFTER), "bad status code")
  `IDV_ASSERT(a_days_zero, (res_valid && res_beat.status != idv_pkg::ST_VALID) |-> (res_beat.days_lived == '0), "day count without valid status")
  `IDV_ASSERT_NORST(a_reset_idle, rst |=> !res_valid, "result valid after reset")

endmodule

bind id_number_date_and_check_digit_validator_unit idv_checker u_idv_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_beat  (res_beat)
);

FILE: bench/tb_id_number_date_and_check_digit_validator_unit.sv
// testbench for the id number validator: streams id numbers through the char channel
// and checks every result against a built-in model; depends on idv_pkg and the unit
`timescale 1ns / 100ps

module tb_id_number_date_and_check_digit_validator_unit;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum {CHK_GOOD, CHK_TEN, CHK_BAD} check_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_stall;
  idv_pkg::char_t char_beat = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  idv_pkg::res_t res_beat;
  logic cfg_we = 1'b0;
  logic [idv_pkg::CFG_ADDR_W-1:0] cfg_addr = idv_pkg::REG_YEAR;
  logic [idv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // model of the stream state and the reference date
  logic [idv_pkg::POS_W-1:0]    id_pos = '0;
  logic [idv_pkg::SUM_W-1:0]    id_sum = '0;
  logic                         saw_nondigit = 1'b0;
  logic [idv_pkg::YEAR_W-1:0]   birth_y = '0;
  logic [idv_pkg::BFIELD_W-1:0] birth_m = '0;
  logic [idv_pkg::BFIELD_W-1:0] birth_d = '0;
  logic [idv_pkg::CHAR_W-1:0]   check_byte = '0;
  logic [idv_pkg::YEAR_W-1:0]   ref_y = idv_pkg::REF_YEAR_RST;
  logic [idv_pkg::MONTH_W-1:0]  ref_m = idv_pkg::REF_MONTH_RST;
  logic [idv_pkg::DAY_W-1:0]    ref_d = idv_pkg::REF_DAY_RST;

  idv_pkg::res_t expected_verdicts[$];
  idv_pkg::res_t want_verdict;
  logic [idv_pkg::CHAR_W-1:0] id_buf [0:31];

  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  id_number_date_and_check_digit_validator_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_beat   (res_beat),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("id_number_date_and_check_digit_validator_unit verification failed");
    $finish;
  end

  // receiver: random stalls, or a counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("result beat with no id pending: status %0d days_lived %0d",
               res_beat.status, res_beat.days_lived);
        fail_count++;
      end else begin
        want_verdict = expected_verdicts.pop_front();
        if (res_beat.status !== want_verdict.status) begin
          $error("status: expected %0d, actual %0d", want_verdict.status, res_beat.status);
          fail_count++;
        end
        if (res_beat.days_lived !== want_verdict.days_lived) begin
          $error("days_lived: expected %0d, actual %0d",
                 want_verdict.days_lived, res_beat.days_lived);
          fail_count++;
        end
      end
    end
  end

  // weight of position p is 2^(17-p) mod 11
  function automatic int pos_weight(input int p);
    int w;
    w = 1;
    for (int k = p; k < 17; k++) w = (w * 2) % 11;
    return w;
  endfunction

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(input int m, input bit lp);
    case (m)
      2:             return lp ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic bit date_exists(input int y, input int m, input int d);
    if (m == 0 || m > 12 || d == 0) return 1'b0;
    return d <= month_days(m, leap_year(y));
  endfunction

  // days since 0000-01-01
  function automatic int day_serial(input int y, input int m, input int d);
    int n;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int k = 1; k < m; k++) n += month_days(k, 1'b0);
    if (m > 2 && leap_year(y)) n++;
    return n + d - 1;
  endfunction

  function automatic logic [idv_pkg::CHAR_W-1:0] digit_char(input int n);
    return idv_pkg::CHAR_W'(int'(idv_pkg::CH_ZERO) + n);
  endfunction

  function automatic bit is_digit(input logic [idv_pkg::CHAR_W-1:0] c);
    return c >= idv_pkg::CH_ZERO && c <= idv_pkg::CH_NINE;
  endfunction

  task automatic track_char(input logic [idv_pkg::CHAR_W-1:0] c, input logic last);
    int dg, want, got, born, refn, span;
    logic [idv_pkg::POS_W-1:0] p;
    idv_pkg::res_t v;
    p = id_pos;
    if (p < idv_pkg::POS_CHECK) begin
      if (is_digit(c)) begin
        dg = int'(c) - int'(idv_pkg::CH_ZERO);
        id_sum = idv_pkg::SUM_W'((int'(id_sum) + dg * pos_weight(p)) % 11);
        if (p >= idv_pkg::POS_YEAR_FIRST && p <= idv_pkg::POS_YEAR_LAST)
          birth_y = idv_pkg::YEAR_W'(int'(birth_y) * 10 + dg);
        else if (p >= idv_pkg::POS_MONTH_FIRST && p <= idv_pkg::POS_MONTH_LAST)
          birth_m = idv_pkg::BFIELD_W'(int'(birth_m) * 10 + dg);
        else if (p >= idv_pkg::POS_DAY_FIRST && p <= idv_pkg::POS_DAY_LAST)
          birth_d = idv_pkg::BFIELD_W'(int'(birth_d) * 10 + dg);
      end else begin
        saw_nondigit = 1'b1;
      end
    end else if (p == idv_pkg::POS_CHECK) begin
      check_byte = c;
    end
    if (p < idv_pkg::POS_SAT) id_pos = p + 1'b1;
    if (last) begin
      v.status = idv_pkg::ST_INVALID;
      v.days_lived = '0;
      if (p == idv_pkg::POS_CHECK && !saw_nondigit &&
          date_exists(birth_y, birth_m, birth_d)) begin
        want = (12 - int'(id_sum)) % 11;
        if (check_byte == idv_pkg::CH_X_UP || check_byte == idv_pkg::CH_X_LO) got = 10;
        else if (is_digit(check_byte)) got = int'(check_byte) - int'(idv_pkg::CH_ZERO);
        else got = 99;
        if (got == want) begin
          v.status = idv_pkg::ST_AFTER;
          if (date_exists(ref_y, ref_m, ref_d)) begin
            born = day_serial(birth_y, birth_m, birth_d);
            refn = day_serial(ref_y, ref_m, ref_d);
            if (born <= refn) begin
              v.status = idv_pkg::ST_VALID;
              span = refn - born;
              v.days_lived = (span > int'(idv_pkg::DAYS_MAX)) ? idv_pkg::DAYS_MAX
                                                               : idv_pkg::DAYS_W'(span);
            end
          end
        end
      end
      expected_verdicts.push_back(v);
      id_pos = '0;
      id_sum = '0;
      saw_nondigit = 1'b0;
      birth_y = '0;
      birth_m = '0;
      birth_d = '0;
      check_byte = '0;
    end
  endtask

  task automatic send_char(input logic [idv_pkg::CHAR_W-1:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_beat.character <= c;
    char_beat.last_char <= last;
    do @(posedge clk); while (char_stall);
    track_char(c, last);
  endtask

  task automatic send_id(input int len);
    for (int i = 0; i < len; i++) send_char(id_buf[i], i == len - 1);
  endtask

  task automatic drain_results();
    char_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ref(input int y, input int m, input int d);
    cfg_we <= 1'b1;
    cfg_addr <= idv_pkg::REG_YEAR;
    cfg_data <= idv_pkg::CFG_DATA_W'(y);
    @(posedge clk);
    cfg_addr <= idv_pkg::REG_MONTH;
    cfg_data <= idv_pkg::CFG_DATA_W'(m);
    @(posedge clk);
    cfg_addr <= idv_pkg::REG_DAY;
    cfg_data <= idv_pkg::CFG_DATA_W'(d);
    @(posedge clk);
    cfg_we <= 1'b0;
    ref_y = idv_pkg::YEAR_W'(y);
    ref_m = idv_pkg::MONTH_W'(m);
    ref_d = idv_pkg::DAY_W'(d);
  endtask

  // fills id_buf with 18 characters carrying the given birth date
  task automatic build_id(input int y, input int m, input int d, input check_kind_t kind);
    int s, v, w;
    bit done;
    done = 1'b0;
    v = 0;
    while (!done) begin
      for (int i = 0; i < 6; i++) id_buf[i] = digit_char($urandom_range(9));
      id_buf[6] = digit_char((y / 1000) % 10);
      id_buf[7] = digit_char((y / 100) % 10);
      id_buf[8] = digit_char((y / 10) % 10);
      id_buf[9] = digit_char(y % 10);
      id_buf[10] = digit_char((m / 10) % 10);
      id_buf[11] = digit_char(m % 10);
      id_buf[12] = digit_char((d / 10) % 10);
      id_buf[13] = digit_char(d % 10);
      for (int i = 14; i < 17; i++) id_buf[i] = digit_char($urandom_range(9));
      s = 0;
      for (int i = 0; i < 17; i++)
        s = (s + (int'(id_buf[i]) - int'(idv_pkg::CH_ZERO)) * pos_weight(i)) % 11;
      v = (12 - s) % 11;
      done = (kind != CHK_TEN) || (v == 10);
    end
    if (kind == CHK_BAD) begin
      case ($urandom_range(2))
        0: begin
          w = (v + 1 + $urandom_range(9)) % 11;
          id_buf[17] = (w == 10) ? idv_pkg::CH_X_LO : digit_char(w);
        end
        1: id_buf[17] = (v == 10) ? digit_char($urandom_range(9)) : idv_pkg::CH_X_UP;
        default: id_buf[17] = idv_pkg::CHAR_W'($urandom_range(255));
      endcase
    end else begin
      id_buf[17] = (v != 10) ? digit_char(v)
                             : ($urandom_range(1) ? idv_pkg::CH_X_UP : idv_pkg::CH_X_LO);
    end
  endtask

  task automatic pick_date(output int y, output int m, output int d);
    y = $urandom_range(1) ? $urandom_range(1900, 2030) : $urandom_range(9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, month_days(m, leap_year(y)));
  endtask

  function automatic logic [idv_pkg::CHAR_W-1:0] pick_nondigit();
    logic [idv_pkg::CHAR_W-1:0] c;
    do c = idv_pkg::CHAR_W'($urandom_range(255)); while (is_digit(c));
    return c;
  endfunction

  task automatic send_good(input int y, input int m, input int d);
    build_id(y, m, d, CHK_GOOD);
    send_id(18);
  endtask

  task automatic test_directed();
    send_good(1990, 5, 17);
    send_good(2019, 4, 2);
    send_good(2019, 4, 3);
    build_id(2000, 2, 29, CHK_TEN);
    id_buf[17] = idv_pkg::CH_X_UP;
    send_id(18);
    build_id(1987, 11, 30, CHK_TEN);
    id_buf[17] = idv_pkg::CH_X_LO;
    send_id(18);
    send_good(1900, 2, 29);
    send_good(0, 2, 29);
    send_good(0, 1, 1);
    send_good(9999, 12, 31);
    send_good(2001, 0, 10);
    send_good(2001, 13, 10);
    send_good(2001, 6, 0);
    send_good(2001, 4, 31);
    send_good(2001, 99, 99);
    build_id(1975, 8, 8, CHK_BAD);
    send_id(18);
    build_id(1975, 8, 8, CHK_GOOD);
    id_buf[3] = 8'h00;
    send_id(18);
    build_id(1975, 8, 8, CHK_GOOD);
    id_buf[16] = 8'hFF;
    send_id(18);
    build_id(1975, 8, 8, CHK_GOOD);
    id_buf[0] = idv_pkg::CH_ZERO - 1'b1;
    id_buf[9] = idv_pkg::CH_NINE + 1'b1;
    send_id(18);
    // wrong lengths, the longest runs the position into saturation
    build_id(1980, 1, 1, CHK_GOOD);
    send_id(1);
    build_id(1980, 1, 1, CHK_GOOD);
    send_id(17);
    build_id(1980, 1, 1, CHK_GOOD);
    for (int i = 18; i < 25; i++) id_buf[i] = idv_pkg::CHAR_W'($urandom_range(255));
    send_id(19);
    build_id(1980, 1, 1, CHK_GOOD);
    send_id(25);
    drain_results();
  endtask

  task automatic ref_case(input int y, input int m, input int d);
    int by, bm, bd;
    drain_results();
    write_ref(y, m, d);
    pick_date(by, bm, bd);
    send_good(by, bm, bd);
    send_good(0, 1, 1);
    send_good(y % 10000, m, d);
    send_good(9999, 12, 31);
  endtask

  task automatic test_ref_dates();
    send_idle_pct = 28;
    stall_pct = 28;
    ref_case(0, 1, 1);
    ref_case(9999, 12, 31);
    ref_case(16383, 12, 31);
    ref_case(2019, 2, 29);
    ref_case(2020, 2, 29);
    ref_case(2019, 0, 5);
    ref_case(2019, 13, 1);
    ref_case(2019, 15, 31);
    ref_case(2019, 4, 31);
    ref_case(2019, 1, 0);
    ref_case(2000, 2, 29);
    drain_results();
  endtask

  task automatic random_stream();
    int r, y, m, d, len;
    r = $urandom_range(99);
    pick_date(y, m, d);
    len = 18;
    if (r < 55) begin
      build_id(y, m, d, ($urandom_range(9) == 0) ? CHK_TEN : CHK_GOOD);
    end else if (r < 65) begin
      build_id(y, m, d, CHK_BAD);
    end else if (r < 73) begin
      build_id(y, $urandom_range(99), $urandom_range(99), CHK_GOOD);
    end else if (r < 81) begin
      build_id(y, m, d, CHK_GOOD);
      id_buf[$urandom_range(16)] = pick_nondigit();
    end else if (r < 91) begin
      build_id(y, m, d, CHK_GOOD);
      len = $urandom_range(1, 25);
      if (len == 18) len = 19;
      for (int i = 18; i < 25; i++) id_buf[i] = idv_pkg::CHAR_W'($urandom_range(255));
    end else begin
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) id_buf[i] = idv_pkg::CHAR_W'($urandom_range(255));
    end
    send_id(len);
  endtask

  task automatic random_phase(input int ids, input int idle_pct, input int stall);
    int y, m, d;
    drain_results();
    if ($urandom_range(4) == 0) begin
      write_ref($urandom_range(16383), $urandom_range(15), $urandom_range(31));
    end else begin
      pick_date(y, m, d);
      write_ref(y, m, d);
    end
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (ids) random_stream();
  endtask

  task automatic test_random_traffic();
    repeat (2) begin
      random_phase(3, 0, 0);
      random_phase(3, 80, 0);
      random_phase(3, 0, 80);
      random_phase(3, 28, 28);
    end
    drain_results();
  endtask

  // long receiver hold-off while the sender keeps going, so the queue fills
  task automatic test_backpressure();
    int y, m, d;
    drain_results();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 300;
    repeat (12) begin
      pick_date(y, m, d);
      send_good(y, m, d);
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_ref_dates();
    test_random_traffic();
    test_backpressure();
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("id_number_date_and_check_digit_validator_unit verification clean");
    end else begin
      $display("id_number_date_and_check_digit_validator_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: id_number_date_and_check_digit_validator_unit.f
+incdir+hw/rtl
hw/rtl/idv_pkg.sv
hw/rtl/idv_queue.sv
hw/rtl/idv_day_num.sv
hw/rtl/idv_front.sv
hw/rtl/idv_back.sv
hw/rtl/id_number_date_and_check_digit_validator_unit.sv
hw/rtl/idv_checker.sv
bench/tb_id_number_date_and_check_digit_validator_unit.sv
